@@ hw/rtl/cfdx_pkg.sv @@
// Shared types and constants for the command frame deframer.
`timescale 1ns / 1ps
`default_nettype none

package cfdx_pkg;

    localparam logic [7:0] START_MARKER_RESET = 8'hAA;
    localparam logic [7:0] MIN_FRAME_LEN      = 8'd3;
    localparam logic [7:0] MAX_FRAME_LEN      = 8'd32;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    localparam logic [7:0] LID_FIRST  = 8'h01;
    localparam logic [7:0] LID_LAST   = 8'h0A;
    localparam logic [7:0] KNOB_FIRST = 8'h10;
    localparam logic [7:0] KNOB_LAST  = 8'h12;

    localparam logic [7:0] FUNC_1 = 8'h01;
    localparam logic [7:0] FUNC_2 = 8'h02;
    localparam logic [7:0] FUNC_3 = 8'h03;
    localparam logic [7:0] FUNC_4 = 8'h04;
    localparam logic [7:0] FUNC_5 = 8'h05;

    localparam logic [7:0] PLEN_ONE_WORD  = 8'd2;
    localparam logic [7:0] PLEN_TWO_WORDS = 8'd4;

    typedef logic [2:0] t_status;
    localparam t_status ST_OK          = 3'd0;
    localparam t_status ST_BAD_LENGTH  = 3'd1;
    localparam t_status ST_BAD_CHECK   = 3'd2;
    localparam t_status ST_BAD_TARGET  = 3'd3;
    localparam t_status ST_BAD_FUNC    = 3'd4;
    localparam t_status ST_BAD_PAYLOAD = 3'd5;

    typedef enum logic [1:0] {
        REC_BAD_LEN = 2'd0,
        REC_BAD_SUM = 2'd1,
        REC_FRAME   = 2'd2
    } t_rec_kind;

    // One finished frame handed from the front end to the decoder.
    typedef struct packed {
        t_rec_kind       kind;
        logic [7:0]      frame_length;
        logic [7:0]      target;
        logic [7:0]      func;
        logic [3:0][7:0] payload;
    } t_frame_rec;

endpackage

`default_nettype wire

@@ hw/rtl/cfdx_front.sv @@
// Front end: hunts for the start marker, checks length and XOR, builds frame records.
`timescale 1ns / 1ps
`default_nettype none

module cfdx_front (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_cfg_we,
    input  wire  [7:0]             i_cfg_wdata,
    input  wire                    i_accept,
    input  wire  [7:0]             i_rx_byte,
    output logic                   o_push,
    output cfdx_pkg::t_frame_rec   o_rec
);
    import cfdx_pkg::*;

    typedef enum logic [2:0] {
        PH_HUNT = 3'b001,
        PH_LEN  = 3'b010,
        PH_BODY = 3'b100
    } t_phase;

    t_phase          r_phase, n_phase;
    logic [7:0]      r_start_marker;
    logic [7:0]      r_frame_length, n_frame_length;
    logic [7:0]      r_bytes_seen, n_bytes_seen;
    logic [7:0]      r_xor, n_xor;
    logic [7:0]      r_target, n_target;
    logic [7:0]      r_func, n_func;
    logic [3:0][7:0] r_payload;
    logic [7:0]      w_seen_inc;
    logic            w_len_bad;
    logic            w_body_more;
    logic            w_pay_we;
    logic [1:0]      w_pay_idx;
    logic [7:0]      w_pay_off;

    assign w_seen_inc  = r_bytes_seen + 8'd1;
    assign w_len_bad   = (i_rx_byte < MIN_FRAME_LEN) || (i_rx_byte > MAX_FRAME_LEN);
    assign w_body_more = w_seen_inc < r_frame_length;
    assign w_pay_off   = r_bytes_seen - 8'd2;
    assign w_pay_idx   = w_pay_off[1:0];

    always_comb begin
        n_phase        = r_phase;
        n_frame_length = r_frame_length;
        n_bytes_seen   = r_bytes_seen;
        n_xor          = r_xor;
        n_target       = r_target;
        n_func         = r_func;
        w_pay_we       = 1'b0;
        o_push         = 1'b0;
        o_rec.kind         = REC_FRAME;
        o_rec.frame_length = r_frame_length;
        o_rec.target       = r_target;
        o_rec.func         = r_func;
        o_rec.payload      = r_payload;
        if (i_accept) begin
            unique case (r_phase)
                PH_LEN: begin
                    if (w_len_bad) begin
                        n_phase    = PH_HUNT;
                        o_push     = 1'b1;
                        o_rec.kind = REC_BAD_LEN;
                    end else begin
                        n_frame_length = i_rx_byte;
                        n_bytes_seen   = 8'd0;
                        n_xor          = r_start_marker ^ i_rx_byte;
                        n_phase        = PH_BODY;
                    end
                end
                PH_BODY: begin
                    if (w_body_more) begin
                        n_xor        = r_xor ^ i_rx_byte;
                        n_bytes_seen = w_seen_inc;
                        if (r_bytes_seen == 8'd0) begin
                            n_target = i_rx_byte;
                        end else if (r_bytes_seen == 8'd1) begin
                            n_func = i_rx_byte;
                        end else if (r_bytes_seen < 8'd6) begin
                            w_pay_we = 1'b1;
                        end
                    end else begin
                        // check byte closes the frame
                        n_phase    = PH_HUNT;
                        o_push     = 1'b1;
                        o_rec.kind = (r_xor == i_rx_byte) ? REC_FRAME : REC_BAD_SUM;
                    end
                end
                default: begin
                    n_phase = (i_rx_byte == r_start_marker) ? PH_LEN : PH_HUNT;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_HUNT;
            r_start_marker <= START_MARKER_RESET;
            r_frame_length <= 8'd0;
            r_bytes_seen   <= 8'd0;
            r_xor          <= 8'd0;
            r_target       <= 8'd0;
            r_func         <= 8'd0;
        end else begin
            r_phase        <= n_phase;
            r_frame_length <= n_frame_length;
            r_bytes_seen   <= n_bytes_seen;
            r_xor          <= n_xor;
            r_target       <= n_target;
            r_func         <= n_func;
            if (i_cfg_we) begin
                r_start_marker <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pay_we) begin
            r_payload[w_pay_idx] <= i_rx_byte;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/cfdx_queue.sv @@
// Short record queue between the front end and the decoder.
`timescale 1ns / 1ps
`default_nettype none

module cfdx_queue (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_push,
    input  cfdx_pkg::t_frame_rec   i_rec,
    input  wire                    i_pop,
    output logic                   o_full,
    output logic                   o_nonempty,
    output cfdx_pkg::t_frame_rec   o_rec
);
    import cfdx_pkg::*;

    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    t_frame_rec            r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   r_wr_ptr;
    logic [QUEUE_AW-1:0]   r_rd_ptr;
    logic [CW-1:0]         r_count;
    logic                  w_do_push;
    logic                  w_do_pop;

    assign o_full     = (r_count == CW'(QUEUE_DEPTH));
    assign o_nonempty = (r_count != '0);
    assign o_rec      = r_mem[r_rd_ptr];
    assign w_do_push  = i_push && !o_full;
    assign w_do_pop   = i_pop && o_nonempty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_do_push) begin
                r_wr_ptr <= (r_wr_ptr == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_do_pop) begin
                r_rd_ptr <= (r_rd_ptr == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_do_push && !w_do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_do_pop && !w_do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr_ptr] <= i_rec;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/cfdx_back.sv @@
// Back end: decodes frame records into command results and holds the output register.
`timescale 1ns / 1ps
`default_nettype none

module cfdx_back (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_rec_valid,
    input  cfdx_pkg::t_frame_rec   i_rec,
    output logic                   o_pop,
    output logic                   o_res_valid,
    input  wire                    i_res_stall,
    output logic [2:0]             o_status,
    output logic                   o_is_knob,
    output logic [3:0]             o_unit,
    output logic [2:0]             o_action,
    output logic [15:0]            o_first_value,
    output logic [15:0]            o_second_value
);
    import cfdx_pkg::*;

    logic        r_valid;
    t_status     r_status, n_status;
    logic        r_is_knob, n_is_knob;
    logic [3:0]  r_unit, n_unit;
    logic [2:0]  r_action, n_action;
    logic [15:0] r_first, n_first;
    logic [15:0] r_second, n_second;
    logic [7:0]  w_plen;
    logic [7:0]  w_lid_off;
    logic [7:0]  w_knob_off;
    logic [15:0] w_word0;
    logic [15:0] w_word2;
    logic        w_is_lid;
    logic        w_is_knob;

    assign w_plen     = i_rec.frame_length - MIN_FRAME_LEN;
    assign w_lid_off  = i_rec.target - LID_FIRST;
    assign w_knob_off = i_rec.target - KNOB_FIRST;
    assign w_word0    = {i_rec.payload[0], i_rec.payload[1]};
    assign w_word2    = {i_rec.payload[2], i_rec.payload[3]};
    assign w_is_lid   = (i_rec.target >= LID_FIRST) && (i_rec.target <= LID_LAST);
    assign w_is_knob  = (i_rec.target >= KNOB_FIRST) && (i_rec.target <= KNOB_LAST);

    // take a new record whenever the output register is free or being drained
    assign o_pop = i_rec_valid && (!r_valid || !i_res_stall);

    always_comb begin
        n_status  = ST_OK;
        n_is_knob = 1'b0;
        n_unit    = 4'd0;
        n_action  = 3'd0;
        n_first   = 16'd0;
        n_second  = 16'd0;
        unique case (i_rec.kind)
            REC_BAD_LEN: n_status = ST_BAD_LENGTH;
            REC_BAD_SUM: n_status = ST_BAD_CHECK;
            default: begin
                if (w_is_lid) begin
                    n_unit = w_lid_off[3:0];
                    unique case (i_rec.func) inside
                        FUNC_1, FUNC_2, FUNC_5: n_action = i_rec.func[2:0];
                        FUNC_3, FUNC_4: begin
                            if (w_plen == PLEN_ONE_WORD) begin
                                n_action = i_rec.func[2:0];
                                n_first  = w_word0;
                            end else begin
                                n_status = ST_BAD_PAYLOAD;
                            end
                        end
                        default: n_status = ST_BAD_FUNC;
                    endcase
                end else if (w_is_knob) begin
                    n_is_knob = 1'b1;
                    n_unit    = w_knob_off[3:0];
                    unique case (i_rec.func) inside
                        FUNC_1: begin
                            if (w_plen == PLEN_TWO_WORDS) begin
                                n_action = i_rec.func[2:0];
                                n_first  = w_word0;
                                n_second = w_word2;
                            end else begin
                                n_status = ST_BAD_PAYLOAD;
                            end
                        end
                        FUNC_2, FUNC_3: begin
                            if (w_plen == PLEN_ONE_WORD) begin
                                n_action = i_rec.func[2:0];
                                n_first  = w_word0;
                            end else begin
                                n_status = ST_BAD_PAYLOAD;
                            end
                        end
                        FUNC_4, FUNC_5: n_action = i_rec.func[2:0];
                        default: n_status = ST_BAD_FUNC;
                    endcase
                end else begin
                    n_status = ST_BAD_TARGET;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (!i_res_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_status  <= n_status;
            r_is_knob <= n_is_knob;
            r_unit    <= n_unit;
            r_action  <= n_action;
            r_first   <= n_first;
            r_second  <= n_second;
        end
    end

    assign o_res_valid    = r_valid;
    assign o_status       = r_status;
    assign o_is_knob      = r_is_knob;
    assign o_unit         = r_unit;
    assign o_action       = r_action;
    assign o_first_value  = r_first;
    assign o_second_value = r_second;

endmodule

`default_nettype wire

@@ hw/rtl/command_frame_deframer_xor_check_top.sv @@
// Command frame deframer with XOR check: top level.
//
// Input channel: one received byte per transaction on i_rx_byte, with i_rx_valid
// and o_rx_stall. Bytes before the start marker are dropped; then a length byte,
// then target, function, payload and a check byte (XOR of marker, length and body).
// Output channel: one result transaction per frame that got past the marker
// (status, is_knob, unit, action, first_value, second_value) on o_res_valid /
// i_res_stall. A bad length yields its result right after the length byte.
// Throughput: one byte per cycle while o_rx_stall is low, set by the front-end byte tracker.
// A result is valid once the record of the byte that closes the frame has passed
// through the chain front end -> two-entry record queue -> decoder output register.
// When the receiver stalls, the result holds; the queue absorbs two more frame
// records, after which o_rx_stall rises until the output is drained.
// i_cfg_we / i_cfg_wdata write the start marker; the value in force when the
// length byte is accepted seeds the check.
// Reset (i_rst_n low, synchronous): hunting, queue empty, no result valid,
// start marker 0xAA.
`timescale 1ns / 1ps
`default_nettype none

module command_frame_deframer_xor_check_top (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_cfg_we,
    input  wire  [7:0]  i_cfg_wdata,
    input  wire         i_rx_valid,
    output logic        o_rx_stall,
    input  wire  [7:0]  i_rx_byte,
    output logic        o_res_valid,
    input  wire         i_res_stall,
    output logic [2:0]  o_status,
    output logic        o_is_knob,
    output logic [3:0]  o_unit,
    output logic [2:0]  o_action,
    output logic [15:0] o_first_value,
    output logic [15:0] o_second_value
);
    import cfdx_pkg::*;

    logic       w_accept;
    logic       w_push;
    logic       w_full;
    logic       w_nonempty;
    logic       w_pop;
    t_frame_rec w_front_rec;
    t_frame_rec w_head_rec;

    assign o_rx_stall = w_full;
    assign w_accept   = i_rx_valid && !w_full;

    cfdx_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_accept    (w_accept),
        .i_rx_byte   (i_rx_byte),
        .o_push      (w_push),
        .o_rec       (w_front_rec)
    );

    cfdx_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (w_push),
        .i_rec      (w_front_rec),
        .i_pop      (w_pop),
        .o_full     (w_full),
        .o_nonempty (w_nonempty),
        .o_rec      (w_head_rec)
    );

    cfdx_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_rec_valid    (w_nonempty),
        .i_rec          (w_head_rec),
        .o_pop          (w_pop),
        .o_res_valid    (o_res_valid),
        .i_res_stall    (i_res_stall),
        .o_status       (o_status),
        .o_is_knob      (o_is_knob),
        .o_unit         (o_unit),
        .o_action       (o_action),
        .o_first_value  (o_first_value),
        .o_second_value (o_second_value)
    );

endmodule

`default_nettype wire
